/* src/kvt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_pkg: shared definitions for the linear key/value table
// Port widths, default sizes, opcodes, state codes and the cell command.
// ---------------------------------------------------------------------------
package kvt_pkg;

  // Fixed port widths
  localparam int KVT_OP_W    = 3;
  localparam int KVT_KEY_PW  = 32;
  localparam int KVT_VAL_PW  = 32;
  localparam int KVT_POS_W   = 8;
  localparam int KVT_CNT_PW  = 9;
  localparam int KVT_LIMIT_W = 9;

  // Default build sizes
  localparam int KVT_CAPACITY    = 256;
  localparam int KVT_KEY_WIDTH   = 32;
  localparam int KVT_VALUE_WIDTH = 32;

  localparam logic [KVT_LIMIT_W-1:0] KVT_LIMIT_RESET = 9'd256;

  typedef enum logic [KVT_OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_UPSERT  = 3'd2,
    OP_ERASE   = 3'd3,
    OP_LOOKUP  = 3'd4,
    OP_READ_AT = 3'd5
  } kvt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } kvt_state_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic search;   // compare against the incoming request
    logic by_pos;   // pick the cell by position instead of by key
    logic update;   // overwrite value in the matching cell
    logic append;   // write key and value into the first free cell
    logic shift;    // pull entries down from the neighbor at and after erase point
  } kvt_cmd_t;

endpackage

/* src/kvt_req_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_req_if: request channel
// Valid/ready channel carrying one table operation.
// ---------------------------------------------------------------------------
interface kvt_req_if import kvt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KVT_OP_W-1:0]    opcode;
  logic [KVT_KEY_PW-1:0]  key_in;
  logic [KVT_VAL_PW-1:0]  value_in;
  logic [KVT_POS_W-1:0]   position;

  modport source (output valid, opcode, key_in, value_in, position, input ready);
  modport sink   (input valid, opcode, key_in, value_in, position, output ready);
endinterface

/* src/kvt_rsp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_rsp_if: result channel
// Valid/ready channel carrying one operation result.
// ---------------------------------------------------------------------------
interface kvt_rsp_if import kvt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   success;
  logic [KVT_KEY_PW-1:0]  key_out;
  logic [KVT_VAL_PW-1:0]  value_out;
  logic [KVT_CNT_PW-1:0]  entry_count;
  logic                   is_empty;

  modport source (output valid, success, key_out, value_out, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, success, key_out, value_out, entry_count, is_empty,
                  output ready);
endinterface

/* src/linear_key_value_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_key_value_table: bounded key/value list with linear search
// Entries sit in a row of cells in insertion order; erase closes the gap.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake        | contents
//  --------+-----+------------------+----------------------------------------
//  in_ch   | in  | valid / ready    | opcode, key_in, value_in, position
//  out_ch  | out | valid / ready    | success, key_out, value_out,
//          |     |                  | entry_count, is_empty
//  cfg     | in  | cfg_we (no wait) | cfg_wdata = capacity limit
//
//  A request has an accept cycle and an apply cycle: in the accept cycle every cell
//  compares its key (and its position) with the request in parallel; in the apply
//  cycle the cells write, append or shift one place down, and the result is registered.
//  Reset clears the sequencer, the output valid and the fill count, and sets the
//  capacity limit to 256; the cells need no clearing since only entries below the
//  count are ever read.
//  The apply cycle holds while the output register is full and not taken;
//  a new request is accepted while a finished result waits.
// ---------------------------------------------------------------------------
module linear_key_value_table import kvt_pkg::*; #(
  parameter int CAPACITY    = KVT_CAPACITY,
  parameter int KEY_WIDTH   = KVT_KEY_WIDTH,
  parameter int VALUE_WIDTH = KVT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  kvt_req_if.sink                in_ch,
  kvt_rsp_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [KVT_LIMIT_W-1:0] cfg_wdata
);

  // Count width, and a common width for count / position / limit compares
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = (CNT_W > KVT_LIMIT_W) ? CNT_W : KVT_LIMIT_W;
  localparam logic [IW-1:0] CAP_X = IW'(CAPACITY);

  kvt_state_t state_r, state_nxt;

  // Held request
  kvt_op_t                op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [KVT_POS_W-1:0]   pos_r;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [KVT_LIMIT_W-1:0] limit_r;

  // Output register
  logic                   out_valid_r;
  logic                   out_success_r;
  logic [KVT_KEY_PW-1:0]  out_key_r;
  logic [KVT_VAL_PW-1:0]  out_value_r;
  logic [KVT_CNT_PW-1:0]  out_count_r;
  logic                   out_empty_r;

  logic accept;
  logic fire;

  kvt_cmd_t               cmd;
  logic [KEY_WIDTH-1:0]   in_key_w;
  logic [KEY_WIDTH-1:0]   bus_key;
  logic [IW-1:0]          cnt_x;
  logic [IW-1:0]          lim_x;
  logic [IW-1:0]          lim_sat;
  logic                   room;

  // Cell row outputs
  logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [KEY_WIDTH-1:0]   pick_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] pick_value [CAPACITY];
  logic [CAPACITY-1:0]    match_vec;

  // Reductions over the row
  logic                   hit;
  logic [IW-1:0]          erase_pos;
  logic [KEY_WIDTH-1:0]   sel_key;
  logic [VALUE_WIDTH-1:0] sel_value;

  // Apply decisions
  logic                   do_update;
  logic                   do_append;
  logic                   do_shift;
  logic                   ok;
  logic [KVT_KEY_PW-1:0]  res_key;
  logic [KVT_VAL_PW-1:0]  res_value;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fire        = (state_r == ST_APPLY) && (!out_valid_r || out_ch.ready);

  assign in_key_w = KEY_WIDTH'(in_ch.key_in);
  assign cnt_x    = IW'(count_r);
  assign lim_x    = IW'(limit_r);
  assign lim_sat  = (lim_x > CAP_X) ? CAP_X : lim_x;
  assign room     = (cnt_x < lim_sat);

  // Search uses the incoming key; apply uses the held key
  assign bus_key = (state_r == ST_IDLE) ? in_key_w : key_r;

  // Fold the row: keys are unique, so at most one cell matches
  always_comb begin
    hit       = 1'b0;
    erase_pos = '0;
    sel_key   = '0;
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | match_vec[i];
      sel_key   = sel_key | pick_key[i];
      sel_value = sel_value | pick_value[i];
      if (match_vec[i]) begin
        erase_pos = erase_pos | IW'(i);
      end
    end
  end

  // Decide what the held request does to the row
  always_comb begin
    do_update = 1'b0;
    do_append = 1'b0;
    do_shift  = 1'b0;
    ok        = 1'b0;
    count_nxt = count_r;
    res_key   = KVT_KEY_PW'(key_r);
    res_value = '0;
    case (op_r)
      OP_INSERT: begin
        if (room && !hit) begin
          do_append = 1'b1;
          ok        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        do_update = hit;
        ok        = hit;
      end
      OP_UPSERT: begin
        if (hit) begin
          do_update = 1'b1;
          ok        = 1'b1;
        end else if (room) begin
          do_append = 1'b1;
          ok        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (hit) begin
          do_shift  = 1'b1;
          ok        = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          ok        = 1'b1;
          res_value = KVT_VAL_PW'(sel_value);
        end
      end
      OP_READ_AT: begin
        if (IW'(pos_r) < cnt_x) begin
          ok        = 1'b1;
          res_key   = KVT_KEY_PW'(sel_key);
          res_value = KVT_VAL_PW'(sel_value);
        end
      end
      default: begin
      end
    endcase
  end

  // Broadcast command: search on accept, write only when the result can leave
  always_comb begin
    cmd.search = accept;
    cmd.by_pos = (kvt_op_t'(in_ch.opcode) == OP_READ_AT);
    cmd.update = fire && do_update;
    cmd.append = fire && do_append;
    cmd.shift  = fire && do_shift;
  end

  // Row of cells; each one pulls from its upper neighbor on erase
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int NB = (g == CAPACITY - 1) ? g : g + 1;

    kvt_cell #(
      .IDX        (g),
      .IW         (IW),
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .req_key   (bus_key),
      .req_value (value_r),
      .req_pos   (IW'(in_ch.position)),
      .count     (cnt_x),
      .erase_pos (erase_pos),
      .nbr_key   (cell_key[NB]),
      .nbr_value (cell_value[NB]),
      .key       (cell_key[g]),
      .value     (cell_value[g]),
      .match     (match_vec[g]),
      .pick_key  (pick_key[g]),
      .pick_value(pick_value[g])
    );
  end

  // Sequencer: idle (accept and search) then apply
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      limit_r     <= KVT_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request for the apply cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= kvt_op_t'(in_ch.opcode);
      key_r   <= in_key_w;
      value_r <= VALUE_WIDTH'(in_ch.value_in);
      pos_r   <= in_ch.position;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_success_r <= ok;
      out_key_r     <= res_key;
      out_value_r   <= res_value;
      out_count_r   <= KVT_CNT_PW'(count_nxt);
      out_empty_r   <= (count_nxt == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.success     = out_success_r;
  assign out_ch.key_out     = out_key_r;
  assign out_ch.value_out   = out_value_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;

endmodule

/* src/kvt_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_cell: one table entry
// Holds a key and a value, compares on search, writes or shifts on apply.
// ---------------------------------------------------------------------------
module kvt_cell import kvt_pkg::*; #(
  parameter int IDX         = 0,
  parameter int IW          = 9,
  parameter int KEY_WIDTH   = KVT_KEY_WIDTH,
  parameter int VALUE_WIDTH = KVT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  kvt_cmd_t               cmd,
  input  logic [KEY_WIDTH-1:0]   req_key,
  input  logic [VALUE_WIDTH-1:0] req_value,
  input  logic [IW-1:0]          req_pos,
  input  logic [IW-1:0]          count,
  input  logic [IW-1:0]          erase_pos,
  input  logic [KEY_WIDTH-1:0]   nbr_key,
  input  logic [VALUE_WIDTH-1:0] nbr_value,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   match,
  output logic [KEY_WIDTH-1:0]   pick_key,
  output logic [VALUE_WIDTH-1:0] pick_value
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   match_r;
  logic                   pick_r;
  logic                   held;
  logic                   key_hit;

  assign held    = (MY_IDX < count);
  assign key_hit = held && (key_r == req_key);

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      match_r <= key_hit;
      pick_r  <= cmd.by_pos ? (held && (MY_IDX == req_pos)) : key_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && (MY_IDX == count)) begin
      key_r   <= req_key;
      value_r <= req_value;
    end else if (cmd.update && match_r) begin
      value_r <= req_value;
    end else if (cmd.shift && (MY_IDX >= erase_pos)) begin
      key_r   <= nbr_key;
      value_r <= nbr_value;
    end
  end

  assign key        = key_r;
  assign value      = value_r;
  assign match      = match_r;
  assign pick_key   = pick_r ? key_r : '0;
  assign pick_value = pick_r ? value_r : '0;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the linear key/value table
// A queue-fed driver sends table requests with random gaps. A shadow copy of
// the table predicts every result, and a monitor with random stalls checks
// each result field by field. The capacity limit is reprogrammed between
// phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench;
  import kvt_pkg::*;

  // Opcodes the block must treat as no-ops
  localparam logic [KVT_OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [KVT_OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam int STALL_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int POOL_SIZE   = 14;    // keys reused within one random phase
  localparam int FILL_KEYS   = 260;   // a few more than the table can hold

  typedef struct {
    logic [KVT_OP_W-1:0]   opcode;
    logic [KVT_KEY_PW-1:0] key;
    logic [KVT_VAL_PW-1:0] value;
    logic [KVT_POS_W-1:0]  position;
  } kv_request_t;

  typedef struct {
    logic                  success;
    logic [KVT_KEY_PW-1:0] key;
    logic [KVT_VAL_PW-1:0] value;
    logic [KVT_CNT_PW-1:0] count;
    logic                  empty;
  } kv_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [KVT_LIMIT_W-1:0] cfg_wdata;

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();

  linear_key_value_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow table: keys and values in insertion order, plus the limit register
  logic [KVT_KEY_PW-1:0] held_keys   [KVT_CAPACITY];
  logic [KVT_VAL_PW-1:0] held_values [KVT_CAPACITY];
  int                    held_count;
  int                    limit_shadow;

  kv_request_t request_q[$];     // requests waiting for the driver
  kv_result_t  expected_rsp_q[$]; // predicted results, oldest first
  kv_request_t on_bus;           // request currently offered on the channel

  logic [KVT_KEY_PW-1:0] pool_keys [POOL_SIZE];
  logic [KVT_KEY_PW-1:0] fill_keys [FILL_KEYS];

  int send_gap, send_calm;
  int recv_stall, recv_calm;
  int mismatches;
  int quiet_cycles;

  // Clock, and known values on every input from time zero
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode   = '0;
    req_ch.key_in   = '0;
    req_ch.value_in = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pick an idle length: mostly none or short, a few long, and now and then
  // a calm stretch with no idling at all.
  function automatic int pick_gap(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Apply one request to the shadow table and return the result it causes.
  function automatic kv_result_t apply_request(kv_request_t rq);
    kv_result_t rs;
    int         at;
    int         room;
    rs.success = 1'b0;
    rs.key     = rq.key;
    rs.value   = '0;
    // The limit saturates at the built capacity
    room = (limit_shadow > KVT_CAPACITY) ? KVT_CAPACITY : limit_shadow;
    at   = -1;
    for (int i = 0; i < held_count; i++)
      if (at < 0 && held_keys[i] == rq.key) at = i;

    case (rq.opcode)
      OP_INSERT: begin
        if (at < 0 && held_count < room) begin
          held_keys[held_count]   = rq.key;
          held_values[held_count] = rq.value;
          held_count++;
          rs.success = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (at >= 0) begin
          held_values[at] = rq.value;
          rs.success = 1'b1;
        end
      end
      OP_UPSERT: begin
        if (at >= 0) begin
          held_values[at] = rq.value;
          rs.success = 1'b1;
        end else if (held_count < room) begin
          held_keys[held_count]   = rq.key;
          held_values[held_count] = rq.value;
          held_count++;
          rs.success = 1'b1;
        end
      end
      OP_ERASE: begin
        // Close the gap: every later entry moves down one place
        if (at >= 0) begin
          for (int i = at; i < held_count - 1; i++) begin
            held_keys[i]   = held_keys[i + 1];
            held_values[i] = held_values[i + 1];
          end
          held_count--;
          rs.success = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (at >= 0) begin
          rs.value   = held_values[at];
          rs.success = 1'b1;
        end
      end
      OP_READ_AT: begin
        if (int'(rq.position) < held_count) begin
          rs.key     = held_keys[rq.position];
          rs.value   = held_values[rq.position];
          rs.success = 1'b1;
        end
      end
      default: ;
    endcase

    rs.count = KVT_CNT_PW'(held_count);
    rs.empty = (held_count == 0);
    return rs;
  endfunction

  task automatic add_request(input logic [KVT_OP_W-1:0] op,
                             input logic [KVT_KEY_PW-1:0] key,
                             input logic [KVT_VAL_PW-1:0] value,
                             input logic [KVT_POS_W-1:0] position);
    kv_request_t rq;
    rq.opcode   = op;
    rq.key      = key;
    rq.value    = value;
    rq.position = position;
    request_q.push_back(rq);
  endtask

  // Random request over the current key pool: mostly hits, some fresh keys.
  task automatic add_random_request();
    int                    roll;
    logic [KVT_OP_W-1:0]   op;
    logic [KVT_KEY_PW-1:0] key;
    logic [KVT_POS_W-1:0]  position;
    roll = $urandom_range(0, 99);
    if (roll < 22)      op = OP_INSERT;
    else if (roll < 32) op = OP_UPDATE;
    else if (roll < 52) op = OP_UPSERT;
    else if (roll < 70) op = OP_ERASE;
    else if (roll < 84) op = OP_LOOKUP;
    else if (roll < 97) op = OP_READ_AT;
    else if (roll < 99) op = OP_RSVD_6;
    else                op = OP_RSVD_7;
    if ($urandom_range(0, 99) < 85) key = pool_keys[$urandom_range(0, POOL_SIZE - 1)];
    else                            key = $urandom;
    if ($urandom_range(0, 99) < 75) position = KVT_POS_W'($urandom_range(0, 15));
    else                            position = KVT_POS_W'($urandom_range(0, 255));
    add_request(op, key, $urandom, position);
  endtask

  // Hold until every request is sent and every result has come back.
  task automatic wait_until_idle();
    @(negedge clk);
    while (request_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the capacity limit; only called while the block is idle.
  task automatic set_capacity_limit(input logic [KVT_LIMIT_W-1:0] limit);
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= limit;
    limit_shadow = int'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic refresh_pool();
    pool_keys[0] = '0;
    pool_keys[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool_keys[i] = $urandom;
  endtask

  // Request driver: predict on every handshake, then offer the next request
  // once the gap has run out.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp_q.push_back(apply_request(on_bus));
        send_gap = pick_gap(send_calm);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          on_bus = request_q.pop_front();
          req_ch.opcode   <= on_bus.opcode;
          req_ch.key_in   <= on_bus.key;
          req_ch.value_in <= on_bus.value;
          req_ch.position <= on_bus.position;
          req_ch.valid    <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each result with the oldest prediction, then
  // stall at random before taking the next one.
  always @(posedge clk) begin
    kv_result_t got;
    kv_result_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.success = rsp_ch.success;
        got.key     = rsp_ch.key_out;
        got.value   = rsp_ch.value_out;
        got.count   = rsp_ch.entry_count;
        got.empty   = rsp_ch.is_empty;
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: ok=%0b key=%h val=%h cnt=%0d",
                     $realtime, got.success, got.key, got.value, got.count);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.success !== want.success || got.key !== want.key ||
              got.value !== want.value || got.count !== want.count ||
              got.empty !== want.empty) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp ok=%0b key=%h val=%h cnt=%0d empty=%0b",
                       $realtime, want.success, want.key, want.value, want.count,
                       want.empty);
              $display("%0t:          got ok=%0b key=%h val=%h cnt=%0d empty=%0b",
                       $realtime, got.success, got.key, got.value, got.count, got.empty);
            end
          end
        end
        recv_stall = pick_gap(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [KVT_KEY_PW-1:0] swap_key;
    int                    pick;
    held_count   = 0;
    limit_shadow = int'(KVT_LIMIT_RESET);
    mismatches   = 0;
    quiet_cycles = 0;
    send_calm    = 0;
    recv_calm    = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-table misses, key extremes, every opcode
    add_request(OP_LOOKUP,  32'h0000_0000, 32'h1111_1111, 8'd0);
    add_request(OP_READ_AT, 32'h0000_0000, 32'h0,         8'd0);
    add_request(OP_ERASE,   32'hFFFF_FFFF, 32'h0,         8'd0);
    add_request(OP_UPDATE,  32'h0000_0000, 32'hDEAD_BEEF, 8'd0);
    add_request(OP_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
    add_request(OP_INSERT,  32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
    add_request(OP_INSERT,  32'h0000_0000, 32'h0000_0001, 8'd0);   // key present
    add_request(OP_UPSERT,  32'h0000_0000, 32'h1234_5678, 8'd0);   // update path
    add_request(OP_UPSERT,  32'h0000_0005, 32'hA5A5_A5A5, 8'd0);   // append path
    add_request(OP_LOOKUP,  32'hFFFF_FFFF, 32'h0,         8'd0);
    add_request(OP_READ_AT, 32'h0000_0000, 32'h0,         8'd0);
    add_request(OP_READ_AT, 32'h0000_0000, 32'h0,         8'd2);
    add_request(OP_READ_AT, 32'h0000_0000, 32'h0,         8'd3);   // past the end
    add_request(OP_READ_AT, 32'hFFFF_FFFF, 32'h0,         8'd255);
    add_request(OP_UPDATE,  32'h0000_0005, 32'h5A5A_5A5A, 8'd0);
    add_request(OP_ERASE,   32'h0000_0000, 32'h0,         8'd0);   // head, shift rest
    add_request(OP_READ_AT, 32'h0000_0000, 32'h0,         8'd0);
    add_request(OP_RSVD_6,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    add_request(OP_RSVD_7,  32'h0000_0005, 32'h0,         8'd1);
    add_request(OP_ERASE,   32'h0000_0005, 32'h0,         8'd0);   // tail
    add_request(OP_ERASE,   32'hFFFF_FFFF, 32'h0,         8'd0);   // now empty
    add_request(OP_ERASE,   32'hFFFF_FFFF, 32'h0,         8'd0);
    add_request(OP_UPSERT,  32'h0000_0077, 32'h0000_0088, 8'd0);
    wait_until_idle();

    // Table full at a small limit
    set_capacity_limit(9'd2);
    add_request(OP_INSERT, 32'h1, 32'h10, 8'd0);
    add_request(OP_INSERT, 32'h2, 32'h20, 8'd0);   // no room
    add_request(OP_UPSERT, 32'h3, 32'h30, 8'd0);   // absent, no room
    add_request(OP_UPSERT, 32'h1, 32'h11, 8'd0);   // present, still allowed
    add_request(OP_INSERT, 32'h77, 32'h0, 8'd0);
    wait_until_idle();

    // Limit dropped below the count: nothing is lost, inserts wait for erases
    set_capacity_limit(9'd1);
    add_request(OP_INSERT, 32'h9, 32'h90, 8'd0);
    add_request(OP_ERASE,  32'h77, 32'h0, 8'd0);
    add_request(OP_INSERT, 32'h9, 32'h90, 8'd0);
    add_request(OP_UPSERT, 32'h9, 32'h91, 8'd0);
    add_request(OP_ERASE,  32'h1, 32'h0,  8'd0);
    add_request(OP_INSERT, 32'h9, 32'h92, 8'd0);
    add_request(OP_LOOKUP, 32'h9, 32'h0,  8'd0);
    wait_until_idle();

    // Fill to the built capacity and read back at random positions and at both ends
    set_capacity_limit(9'd256);
    for (int i = 0; i < FILL_KEYS; i++) fill_keys[i] = $urandom;
    for (int i = 0; i < FILL_KEYS; i++) begin
      add_request(OP_INSERT, fill_keys[i], $urandom, KVT_POS_W'($urandom_range(0, 255)));
      if (i % 4 == 3)
        add_request(OP_READ_AT, $urandom, 32'h0, KVT_POS_W'($urandom_range(0, 255)));
      if (i % 8 == 5) add_request(OP_LOOKUP, fill_keys[$urandom_range(0, i)], 32'h0, 8'd0);
    end
    add_request(OP_UPSERT, $urandom, $urandom, 8'd0);
    add_request(OP_UPSERT, fill_keys[3], $urandom, 8'd0);
    add_request(OP_READ_AT, 32'h0, 32'h0, 8'd255);
    add_request(OP_READ_AT, 32'h0, 32'h0, 8'd254);
    add_request(OP_READ_AT, 32'h0, 32'h0, 8'd0);
    for (int i = 0; i < 40; i++)
      add_request(OP_READ_AT, $urandom, $urandom, KVT_POS_W'($urandom_range(0, 255)));
    wait_until_idle();

    // Lower the limit on a full table, then drain it in random order
    set_capacity_limit(9'd255);
    add_request(OP_INSERT, $urandom, $urandom, 8'd0);
    add_request(OP_ERASE, fill_keys[100], 32'h0, 8'd0);
    add_request(OP_INSERT, 32'hCAFE_0001, $urandom, 8'd0);
    add_request(OP_ERASE, fill_keys[0], 32'h0, 8'd0);
    add_request(OP_INSERT, 32'hCAFE_0002, $urandom, 8'd0);
    for (int i = FILL_KEYS - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      swap_key = fill_keys[i];
      fill_keys[i] = fill_keys[pick];
      fill_keys[pick] = swap_key;
    end
    for (int i = 0; i < FILL_KEYS; i++) begin
      add_request(OP_ERASE, fill_keys[i], $urandom, KVT_POS_W'($urandom_range(0, 255)));
      if (i % 6 == 2)
        add_request(OP_READ_AT, $urandom, 32'h0, KVT_POS_W'($urandom_range(0, 255)));
    end
    add_request(OP_ERASE, 32'h9, 32'h0, 8'd0);
    add_request(OP_ERASE, 32'hCAFE_0002, 32'h0, 8'd0);
    wait_until_idle();

    // Random phases over a small key pool at several limits, with a full
    // pause halfway through each one
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_capacity_limit(9'd511);
        1: set_capacity_limit(9'd7);
        2: set_capacity_limit(9'd0);
        3: set_capacity_limit(KVT_LIMIT_W'($urandom_range(1, 256)));
        default: set_capacity_limit(9'd256);
      endcase
      refresh_pool();
      for (int i = 0; i < 110; i++) add_random_request();
      wait_until_idle();
      for (int i = 0; i < 110; i++) add_random_request();
      wait_until_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsp_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
